/* design/modbus_request_frame_builder_unit_assert.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the Modbus request frame builder
// Clocked property wrappers used by the port checker.
// -----------------------------------------------------------------------------
`ifndef MODBUS_REQUEST_FRAME_BUILDER_UNIT_ASSERT_SVH
`define MODBUS_REQUEST_FRAME_BUILDER_UNIT_ASSERT_SVH

// Check a property outside of reset
`define MRFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included
`define MRFB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/mrfb_pkg.sv */
// -----------------------------------------------------------------------------
// Modbus request frame builder package
// Shared constants, register indexes, frame positions and the CRC byte step.
// -----------------------------------------------------------------------------
package mrfb_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] UNIT_ID_RESET = 8'h03;
  localparam logic [7:0] FUNCTION_CODE_RESET = 8'h10;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_UNIT_ID       = 8'd0,
    REG_FUNCTION_CODE = 8'd1
  } cfg_reg_t;

  // Byte positions within one frame, in send order
  typedef enum logic [2:0] {
    POS_UNIT_ID   = 3'd0,
    POS_FUNC_CODE = 3'd1,
    POS_ADDR_HI   = 3'd2,
    POS_ADDR_LO   = 3'd3,
    POS_VALUE_HI  = 3'd4,
    POS_VALUE_LO  = 3'd5,
    POS_CRC_LO    = 3'd6,
    POS_CRC_HI    = 3'd7
  } frame_pos_t;

  // One write request
  typedef struct packed {
    logic [15:0] reg_value;
    logic [15:0] reg_address;
  } request_t;

  // Fold one byte into a CRC-16/MODBUS remainder, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* design/mrfb_serializer.sv */
// -----------------------------------------------------------------------------
// Modbus request frame serializer
// Sends one request as eight bytes and folds the CRC in one byte per cycle while the receiver takes bytes.
// -----------------------------------------------------------------------------
module mrfb_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_valid,
  output logic                 load_ready,
  input  mrfb_pkg::request_t   load_req,
  input  logic [7:0]           unit_id,
  input  logic [7:0]           function_code,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,   // [7:0] frame_byte
  output logic                 out_tlast    // last_byte
);

  logic                  active_r, active_nxt;
  mrfb_pkg::frame_pos_t  pos_r, pos_nxt;
  mrfb_pkg::request_t    req_r, req_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic [7:0]            byte_sel;
  logic                  fire;
  logic                  at_last;

  // Pick the byte at the current frame position
  always_comb begin
    unique case (pos_r)
      mrfb_pkg::POS_UNIT_ID:   byte_sel = unit_id;
      mrfb_pkg::POS_FUNC_CODE: byte_sel = function_code;
      mrfb_pkg::POS_ADDR_HI:   byte_sel = req_r.reg_address[15:8];
      mrfb_pkg::POS_ADDR_LO:   byte_sel = req_r.reg_address[7:0];
      mrfb_pkg::POS_VALUE_HI:  byte_sel = req_r.reg_value[15:8];
      mrfb_pkg::POS_VALUE_LO:  byte_sel = req_r.reg_value[7:0];
      mrfb_pkg::POS_CRC_LO:    byte_sel = crc_r[7:0];
      mrfb_pkg::POS_CRC_HI:    byte_sel = crc_r[15:8];
      default:                 byte_sel = crc_r[15:8];
    endcase
  end

  assign fire       = active_r && out_tready;
  assign at_last    = (pos_r == mrfb_pkg::POS_CRC_HI);
  assign load_ready = !active_r || (fire && at_last);

  assign out_tvalid = active_r;
  assign out_tdata  = byte_sel;
  assign out_tlast  = at_last;

  // Load a new frame, or advance one byte per transaction
  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    req_nxt    = req_r;
    crc_nxt    = crc_r;
    if (load_valid && load_ready) begin
      active_nxt = 1'b1;
      pos_nxt    = mrfb_pkg::POS_UNIT_ID;
      req_nxt    = load_req;
      crc_nxt    = mrfb_pkg::CRC_INIT;
    end else if (fire) begin
      pos_nxt = mrfb_pkg::frame_pos_t'(pos_r + 3'd1);
      if (at_last) begin
        active_nxt = 1'b0;
      end
      if (pos_r < mrfb_pkg::POS_CRC_LO) begin
        crc_nxt = mrfb_pkg::crc16_byte(crc_r, byte_sel);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= mrfb_pkg::POS_UNIT_ID;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    crc_r <= crc_nxt;
  end

endmodule

/* design/modbus_request_frame_builder_unit.sv */
// -----------------------------------------------------------------------------
// Modbus request frame builder
// Turns register write requests into Modbus RTU frames with CRC-16/MODBUS.
// -----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per transaction, tdata = {reg_value, reg_address}.
//   out_*  : eight byte transactions per request: unit id, function code,
//            address high/low, value high/low, CRC low/high; tlast marks the
//            CRC high byte.
//   cfg_*  : register writes (index 0 unit id, 1 function code), always
//            ready; other indexes are dropped. Write only while idle.
// Path: a taken request is registered in the input buffer, then loaded into
//   the serializer, whose registered active state drives out_tvalid.
// Frames go out back to back with no gap while the next request waits in
//   the buffer. The CRC is folded one byte per sent byte, so it is ready
//   when the CRC low byte is due.
// A one-entry input buffer takes the next request while a frame is still
//   being sent. A stalled receiver holds the current byte; the buffer fills
//   and in_tready drops until the frame drains.
// Reset: buffers empty, no frame in flight, unit id 3, function code 16.
// -----------------------------------------------------------------------------
module modbus_request_frame_builder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mrfb_pkg::InDataW-1:0]   in_tdata,   // [15:0] reg_address, [31:16] reg_value
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mrfb_pkg::OutDataW-1:0]  out_tdata,  // [7:0] frame_byte
  output logic                           out_tlast,  // last_byte
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrfb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mrfb_pkg::CfgDataW-1:0]  cfg_data
);

  logic                hold_valid_r, hold_valid_nxt;
  mrfb_pkg::request_t  hold_req_r, hold_req_nxt;
  logic [7:0]          unit_id_r, unit_id_nxt;
  logic [7:0]          function_code_r, function_code_nxt;
  logic                ser_ready;
  logic                in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !hold_valid_r || ser_ready;
  assign in_fire   = in_tvalid && in_tready;

  // Update configuration registers, drop unknown indexes
  always_comb begin
    unit_id_nxt       = unit_id_r;
    function_code_nxt = function_code_r;
    if (cfg_valid) begin
      if (cfg_index == mrfb_pkg::REG_UNIT_ID) begin
        unit_id_nxt = cfg_data;
      end else if (cfg_index == mrfb_pkg::REG_FUNCTION_CODE) begin
        function_code_nxt = cfg_data;
      end
    end
  end

  // Hold one request until the serializer takes it
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_req_nxt   = hold_req_r;
    if (in_fire) begin
      hold_valid_nxt = 1'b1;
      hold_req_nxt   = mrfb_pkg::request_t'(in_tdata);
    end else if (ser_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r    <= 1'b0;
      unit_id_r       <= mrfb_pkg::UNIT_ID_RESET;
      function_code_r <= mrfb_pkg::FUNCTION_CODE_RESET;
    end else begin
      hold_valid_r    <= hold_valid_nxt;
      unit_id_r       <= unit_id_nxt;
      function_code_r <= function_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_req_r <= hold_req_nxt;
  end

  mrfb_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_valid    (hold_valid_r),
    .load_ready    (ser_ready),
    .load_req      (hold_req_r),
    .unit_id       (unit_id_r),
    .function_code (function_code_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule

/* design/mrfb_checker.sv */
// -----------------------------------------------------------------------------
// Modbus request frame builder port checker
// Watches the top-level ports for frame framing, CRC and stall behavior.
// -----------------------------------------------------------------------------
`include "modbus_request_frame_builder_unit_assert.svh"

module mrfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,   // [7:0] frame_byte
  input logic        out_tlast    // last_byte
);

  logic [2:0]  cnt_r;
  logic [15:0] crc_r;
  logic        out_fire;
  logic        out_stall;
  logic [8:0]  out_beat;
  logic        at_crc;
  logic        at_last;
  logic [7:0]  crc_exp;

  assign out_fire  = out_tvalid && out_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_beat  = {out_tlast, out_tdata};
  assign at_last   = (cnt_r == mrfb_pkg::POS_CRC_HI);
  assign at_crc    = (cnt_r == mrfb_pkg::POS_CRC_LO) || at_last;
  assign crc_exp   = at_last ? crc_r[15:8] : crc_r[7:0];

  // Track the position and running CRC of the frame on the wire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      crc_r <= mrfb_pkg::CRC_INIT;
    end else if (out_fire) begin
      cnt_r <= cnt_r + 3'd1;
      if (at_last) begin
        crc_r <= mrfb_pkg::CRC_INIT;
      end else if (cnt_r < mrfb_pkg::POS_CRC_LO) begin
        crc_r <= mrfb_pkg::crc16_byte(crc_r, out_tdata);
      end
    end
  end

  `MRFB_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "output valid right after reset")
  `MRFB_ASSERT(a_stall_hold, out_stall |=> out_tvalid && $stable(out_beat), "stall not held")
  `MRFB_ASSERT(a_last_pos, out_tvalid |-> (out_tlast == at_last), "tlast not on eighth byte")
  `MRFB_ASSERT(a_crc_bytes, out_tvalid && at_crc |-> out_tdata == crc_exp, "CRC byte mismatch")
  `MRFB_ASSERT(a_idle_ready, !out_tvalid |-> in_tready, "input stalled while output idle")

endmodule

bind modbus_request_frame_builder_unit mrfb_checker u_mrfb_checker (.*);

/* tb/sv/tb_modbus_request_frame_builder_unit.sv */
// -----------------------------------------------------------------------------
// Testbench for the Modbus request frame builder
// Drives register write requests with random gaps, stalls the byte stream at
// random, predicts every frame byte and its CRC-16/MODBUS, and checks each
// byte transaction in order. Unit id and function code are changed between
// phases, including the extreme values and writes to unused indexes.
// -----------------------------------------------------------------------------
module tb_modbus_request_frame_builder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] REG_IDX_SPARE = 8'd2;    // first index with no register
  localparam int         FRAME_BYTES   = 8;
  localparam int         LONG_HOLD     = 150;     // receiver hold-off in cycles
  localparam int         DRAIN_CYCLES  = 16;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;

  // Request stream and expected byte stream
  mrfb_pkg::request_t req_queue[$];
  frame_byte_t        frame_bytes_due[$];
  frame_byte_t        due;

  // Predictor copy of the registers
  logic [7:0]  unit_id_q   = mrfb_pkg::UNIT_ID_RESET;
  logic [7:0]  func_code_q = mrfb_pkg::FUNCTION_CODE_RESET;

  int n_sent      = 0;
  int n_accepted  = 0;
  int n_frames    = 0;
  int n_cfg       = 0;
  int n_errors    = 0;
  int in_gap_max  = 8;
  int out_gap_max = 8;
  int in_gap_left = 0;
  int out_gap_left = 0;
  int hold_left   = 0;
  int hold_req    = 0;
  int hold_seen   = 0;
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  modbus_request_frame_builder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold one byte into a CRC-16/MODBUS remainder, one bit at a time
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        lsb;
    r = crc ^ {8'h00, b};
    repeat (8) begin
      lsb = r[0];
      r   = {1'b0, r[15:1]};
      if (lsb) r = r ^ mrfb_pkg::CRC_POLY;
    end
    return r;
  endfunction

  // Build the eight bytes of one request frame and queue them
  function automatic void predict_frame(input mrfb_pkg::request_t req);
    logic [7:0]  bytes[FRAME_BYTES];
    logic [15:0] crc;
    frame_byte_t fb;
    bytes[mrfb_pkg::POS_UNIT_ID]   = unit_id_q;
    bytes[mrfb_pkg::POS_FUNC_CODE] = func_code_q;
    bytes[mrfb_pkg::POS_ADDR_HI]   = req.reg_address[15:8];
    bytes[mrfb_pkg::POS_ADDR_LO]   = req.reg_address[7:0];
    bytes[mrfb_pkg::POS_VALUE_HI]  = req.reg_value[15:8];
    bytes[mrfb_pkg::POS_VALUE_LO]  = req.reg_value[7:0];
    crc = mrfb_pkg::CRC_INIT;
    for (int i = 0; i < mrfb_pkg::POS_CRC_LO; i++) crc = crc_fold(crc, bytes[i]);
    bytes[mrfb_pkg::POS_CRC_LO] = crc[7:0];
    bytes[mrfb_pkg::POS_CRC_HI] = crc[15:8];
    for (int i = 0; i < FRAME_BYTES; i++) begin
      fb.data = bytes[i];
      fb.last = (i == mrfb_pkg::POS_CRC_HI);
      frame_bytes_due.push_back(fb);
    end
  endfunction

  // Drive requests: hold until taken, then wait the drawn gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else if (in_gap_left > 0) begin
      in_gap_left <= in_gap_left - 1;
      in_tvalid   <= 1'b0;
    end else if (req_queue.size() > 0) begin
      in_tvalid   <= 1'b1;
      in_tdata    <= req_queue.pop_front();
      in_gap_left <= $urandom_range(0, in_gap_max);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: random stall after each byte, plus requested long hold-offs
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (out_taken) out_gap_left = $urandom_range(0, out_gap_max);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_gap_left > 0) begin
        out_gap_left = out_gap_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: track handshakes, predict on request, check on byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        if (cfg_index == mrfb_pkg::REG_UNIT_ID) unit_id_q = cfg_data;
        else if (cfg_index == mrfb_pkg::REG_FUNCTION_CODE) func_code_q = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        predict_frame(mrfb_pkg::request_t'(in_tdata));
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected byte transaction, expected none, actual data %02h last %0b",
                   $realtime, out_tdata, out_tlast);
          n_errors++;
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_tdata !== due.data) begin
            $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                     $realtime, due.data, out_tdata);
            n_errors++;
          end
          if (out_tlast !== due.last) begin
            $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                     $realtime, due.last, out_tlast);
            n_errors++;
          end
          if (due.last) n_frames++;
        end
      end
    end
  end

  // Queue one request for the driver
  task automatic send_request(input logic [15:0] addr, input logic [15:0] value);
    mrfb_pkg::request_t r;
    r.reg_address = addr;
    r.reg_value   = value;
    req_queue.push_back(r);
    n_sent++;
  endtask

  // Wait until every request is taken and every byte has come out
  task automatic wait_idle();
    forever begin
      @(negedge clk);
      if (n_accepted == n_sent && frame_bytes_due.size() == 0) break;
    end
    repeat (4) @(negedge clk);
  endtask

  // One register write transaction; valid stays up for a following write
  task automatic cfg_write(input logic [7:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Uniform words half the time, corner patterns the other half
  function automatic logic [15:0] rand_word();
    unique case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001 << $urandom_range(0, 15);
      3:       return ~(16'h0001 << $urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_request(rand_word(), rand_word());
  endtask

  // Stimulus
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unused indexes must leave the reset values in place
    cfg_write(REG_IDX_SPARE, 8'h55);
    cfg_write(8'hFF, 8'hAA);
    cfg_release();

    // Directed: field extremes and byte-order patterns at reset settings
    send_request(16'h0000, 16'h0000);
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'h0000, 16'hFFFF);
    send_request(16'hFFFF, 16'h0000);
    send_request(16'h8000, 16'h0001);
    send_request(16'h0001, 16'h8000);
    send_request(16'h00FF, 16'hFF00);
    send_request(16'hAAAA, 16'h5555);
    send_request(16'h1234, 16'h5678);
    // Repeat one request: each frame must come out the same
    send_request(16'h0001, 16'h0003);
    send_request(16'h0001, 16'h0003);
    send_request(16'h0001, 16'h0003);
    wait_idle();

    // Directed: register extremes
    cfg_write(mrfb_pkg::REG_UNIT_ID, 8'h00);
    cfg_write(mrfb_pkg::REG_FUNCTION_CODE, 8'h00);
    cfg_release();
    send_request(16'h0000, 16'h0000);
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'hA5A5, 16'h5A5A);
    wait_idle();
    cfg_write(mrfb_pkg::REG_UNIT_ID, 8'hFF);
    cfg_write(mrfb_pkg::REG_FUNCTION_CODE, 8'hFF);
    cfg_release();
    send_request(16'h0000, 16'h0000);
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'h8001, 16'h7FFE);
    wait_idle();

    // Random settings, random gaps on both sides
    cfg_write(mrfb_pkg::REG_UNIT_ID, 8'($urandom_range(1, 254)));
    cfg_write(mrfb_pkg::REG_FUNCTION_CODE, 8'($urandom_range(1, 254)));
    cfg_release();
    send_random(50);
    wait_idle();

    // Long receiver hold-off while the sender bursts: input must stall
    cfg_write(mrfb_pkg::REG_UNIT_ID, 8'h00);
    cfg_write(mrfb_pkg::REG_FUNCTION_CODE, 8'hFF);
    cfg_release();
    in_gap_max = 0;
    @(posedge clk);
    hold_req++;
    send_random(12);
    wait_idle();

    // Back to back on both sides, no idling at all
    out_gap_max = 0;
    send_random(40);
    wait_idle();
    in_gap_max  = 8;
    out_gap_max = 8;

    // Extreme settings with random gaps; a spare-index write in between
    cfg_write(mrfb_pkg::REG_UNIT_ID, 8'hFF);
    cfg_write(8'($urandom_range(REG_IDX_SPARE, 255)), 8'($urandom_range(0, 255)));
    cfg_write(mrfb_pkg::REG_FUNCTION_CODE, 8'h00);
    cfg_release();
    send_random(50);
    wait_idle();

    // Random settings, slow receiver only
    cfg_write(mrfb_pkg::REG_FUNCTION_CODE, 8'($urandom_range(0, 255)));
    cfg_write(mrfb_pkg::REG_UNIT_ID, 8'($urandom_range(0, 255)));
    cfg_release();
    in_gap_max = 0;
    send_random(50);
    wait_idle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (frame_bytes_due.size() != 0) begin
      $display("%0t: leftover bytes, expected 0 pending, actual %0d pending",
               $realtime, frame_bytes_due.size());
      n_errors++;
    end
    $display("Covered %0d requests, %0d frames and %0d register writes,", n_sent, n_frames,
             n_cfg);
    $display("with random gaps, a long receiver hold-off and back-to-back bursts.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout", $realtime);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* modbus_request_frame_builder_unit.f */
+incdir+design
design/mrfb_pkg.sv
design/mrfb_serializer.sv
design/modbus_request_frame_builder_unit.sv
design/mrfb_checker.sv
tb/sv/tb_modbus_request_frame_builder_unit.sv
